FILE: src/mlf_pkg.sv
// ----------------------------------------------------------------------------
// mlf_pkg: shared types and constants of the match length factorizer
// Field widths, operation codes, sequencer state codes and the match length
// rule that turns two common-prefix values into a stored length.
// ----------------------------------------------------------------------------
`default_nettype none

package mlf_pkg;

  // field widths
  localparam int unsigned LCP_W   = 18;  // signed common-prefix values
  localparam int unsigned LEN_W   = 17;  // stored match length
  localparam int unsigned POS_W   = 16;  // text position / walk position
  localparam int unsigned TOTAL_W = 17;  // total_length register
  localparam int unsigned START_W = 15;  // factor start in the forward strand
  localparam int unsigned FLEN_W  = 16;  // clipped factor length

  // smallest length that is ever stored
  localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(1);

  // operation codes carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WALK = 1'b1;

  // sequencer states
  typedef logic [0:0] state_t;
  localparam state_t ST_IDLE = 1'b0;
  localparam state_t ST_READ = 1'b1;

  // larger of the two prefix values, raised to at least one
  function automatic logic [LEN_W-1:0] match_len(
    input logic signed [LCP_W-1:0] lcp_a,
    input logic signed [LCP_W-1:0] lcp_b
  );
    logic signed [LCP_W-1:0] m;
    m = (lcp_a > lcp_b) ? lcp_a : lcp_b;
    if (m < $signed({{(LCP_W-LEN_W){1'b0}}, MIN_MATCH})) begin
      m = $signed({{(LCP_W-LEN_W){1'b0}}, MIN_MATCH});
    end
    return m[LEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/mlf_store.sv
// ----------------------------------------------------------------------------
// mlf_store: match length memory
// Computes the match length of a load transfer and writes it at the text
// position; one synchronous read port with registered data for the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mlf_store #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  wire                                clk_i,
  input  wire                                wr_en_i,
  input  wire  [ADDR_W-1:0]                  wr_addr_i,
  input  wire  signed [mlf_pkg::LCP_W-1:0]   lcp_here_i,
  input  wire  signed [mlf_pkg::LCP_W-1:0]   lcp_next_i,
  input  wire                                rd_en_i,
  input  wire  [ADDR_W-1:0]                  rd_addr_i,
  output logic [mlf_pkg::LEN_W-1:0]          rd_data_o
);

  logic [mlf_pkg::LEN_W-1:0] mem_q [DEPTH];
  logic [mlf_pkg::LEN_W-1:0] wr_data;

  // length to store for this suffix array entry
  assign wr_data = mlf_pkg::match_len(lcp_here_i, lcp_next_i);

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/match_length_factorizer_core.sv
// ----------------------------------------------------------------------------
// match_length_factorizer_core: match factors of the forward strand
// Load transfers fill the match length memory from suffix array entries;
// walk transfers step through the forward strand and emit one factor each while the walk is live.
// ----------------------------------------------------------------------------
// sequence: a load writes the length memory in its transfer; a live walk reads the
//   memory, then clips, updates and registers its factor once the output is free
// throughput: one load per cycle while idle; a walk holds tready low until its
//   factor is committed, so no new transfer is taken before that
// reset: walk position and end flag clear, total_length returns to 2;
//   the length memory is not cleared and holds garbage until written
`default_nettype none

module match_length_factorizer_core #(
  parameter int unsigned MAX_TEXT = 65536
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // input stream
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire  [55:0]                     s_axis_tdata_i,  // sa_value, lcp_here, lcp_next
  input  wire                             s_axis_tuser_i,  // op
  // result stream
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  output logic [31:0]                     m_axis_tdata_o,  // factor_start, factor_length
  output logic                            m_axis_tlast_o,  // last_factor
  // configuration write channel
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [mlf_pkg::TOTAL_W-1:0]     cfg_data_i       // total_length
);

  localparam int unsigned ADDR_W = $clog2(MAX_TEXT);

  // input field split
  logic                              in_op;
  logic [mlf_pkg::POS_W-1:0]         sa_value;
  logic signed [mlf_pkg::LCP_W-1:0]  lcp_here;
  logic signed [mlf_pkg::LCP_W-1:0]  lcp_next;

  assign in_op    = s_axis_tuser_i;
  assign sa_value = s_axis_tdata_i[15:0];
  assign lcp_here = $signed(s_axis_tdata_i[33:16]);
  assign lcp_next = $signed(s_axis_tdata_i[51:34]);

  // registers
  mlf_pkg::state_t                   state_q, state_d;
  logic [mlf_pkg::TOTAL_W-1:0]       total_q;
  logic [mlf_pkg::POS_W-1:0]         pos_q, pos_d;
  logic                              fin_q, fin_d;
  logic                              out_valid_q, out_valid_d;
  logic [mlf_pkg::START_W-1:0]       out_start_q, out_start_d;
  logic [mlf_pkg::FLEN_W-1:0]        out_len_q, out_len_d;
  logic                              out_last_q, out_last_d;

  // handshakes
  logic in_xfer, load_xfer, walk_xfer, out_free, commit;
  logic [mlf_pkg::POS_W-1:0] half;
  logic walk_live;

  assign s_axis_tready_o = (state_q == mlf_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_xfer = in_xfer && (in_op == mlf_pkg::OP_LOAD);
  assign walk_xfer = in_xfer && (in_op == mlf_pkg::OP_WALK);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign half      = total_q[mlf_pkg::TOTAL_W-1:1];
  assign walk_live = !fin_q && (pos_q < half);
  assign commit    = (state_q == mlf_pkg::ST_READ) && out_free;

  // memory addressing
  logic [31:0]       sa_wide, pos_wide;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [mlf_pkg::LEN_W-1:0] rd_len;

  assign sa_wide  = 32'(sa_value);
  assign pos_wide = 32'(pos_q);
  assign wr_addr  = sa_wide[ADDR_W-1:0];
  assign rd_addr  = pos_wide[ADDR_W-1:0];
  assign wr_en    = load_xfer && (sa_wide < 32'(MAX_TEXT));
  assign rd_en    = walk_xfer && walk_live;

  mlf_store #(
    .DEPTH  (MAX_TEXT),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .lcp_here_i (lcp_here),
    .lcp_next_i (lcp_next),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_len)
  );

  // clip against the strand end
  logic [mlf_pkg::POS_W-1:0] remaining;
  logic                      reaches_end;

  assign remaining   = half - pos_q;
  assign reaches_end = rd_len >= {1'b0, remaining};

  // walk sequencer and output register
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_start_d = out_start_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    case (state_q)
      mlf_pkg::ST_IDLE: begin
        if (walk_xfer) begin
          if (walk_live) begin
            state_d = mlf_pkg::ST_READ;
          end else begin
            fin_d = 1'b1;
          end
        end
      end
      mlf_pkg::ST_READ: begin
        if (commit) begin
          state_d     = mlf_pkg::ST_IDLE;
          out_valid_d = 1'b1;
          out_start_d = pos_q[mlf_pkg::START_W-1:0];
          if (reaches_end) begin
            out_len_d  = remaining;
            out_last_d = 1'b1;
            fin_d      = 1'b1;
          end else begin
            out_len_d  = rd_len[mlf_pkg::FLEN_W-1:0];
            out_last_d = 1'b0;
            pos_d      = pos_q + rd_len[mlf_pkg::POS_W-1:0];
          end
        end
      end
      default: begin
        state_d = mlf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlf_pkg::ST_IDLE;
      pos_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= mlf_pkg::TOTAL_W'(2);
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_start_q <= out_start_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_start_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // a result only appears right after a memory read completes
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == mlf_pkg::ST_READ))
    else $error("result appeared without a completed walk read");

  // entering the read state always follows an issued read
  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mlf_pkg::ST_READ) && !$past(state_q == mlf_pkg::ST_READ)
      |-> $past(rd_en))
    else $error("read state entered without a memory read");

  // the walk never restarts without reset
  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("walk end flag cleared");

  // a last factor leaves the walk finished
  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> fin_q)
    else $error("last factor without walk end");
`endif

endmodule

`default_nettype wire
